// ----- hdl/sm4_pkg.sv -----
// Shared types, constants and round functions of the SM4 cipher unit.
package sm4_pkg;

  localparam int unsigned NUM_ROUNDS = 32;
  localparam int unsigned RK_IDX_W   = $clog2(NUM_ROUNDS);
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(1);

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        action;
  } sm4_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } sm4_out_t;

  // Cipher state, word X0 in the top 32 bits and X3 in the bottom 32 bits.
  typedef logic [127:0] sm4_state_t;

  localparam logic [31:0] FK_TAB [4] = '{
    32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
  };

  localparam logic [7:0] SBOX_TAB [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
    8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
    8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
    8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
    8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
    8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
    8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
    8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
    8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
    8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
    8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
    8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
    8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
    8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
    8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
    8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
    8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
    8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
    8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
    8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
  };

  function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Byte-wise S-box substitution of one word.
  function automatic logic [31:0] tau(logic [31:0] v);
    return {SBOX_TAB[v[31:24]], SBOX_TAB[v[23:16]], SBOX_TAB[v[15:8]], SBOX_TAB[v[7:0]]};
  endfunction

  function automatic logic [31:0] lin_data(logic [31:0] b);
    return b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
  endfunction

  function automatic logic [31:0] lin_key(logic [31:0] b);
    return b ^ rotl32(b, 13) ^ rotl32(b, 23);
  endfunction

  // CK word of round i: byte j (most significant first) is (4i+j)*7 mod 256.
  function automatic logic [31:0] ck_word(logic [RK_IDX_W-1:0] i);
    logic [31:0] w;
    logic [7:0]  n;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      n = {1'b0, i, 2'(j)};
      w = {w[23:0], 8'(n * 8'd7)};
    end
    return w;
  endfunction

  // One cipher round: shift the words and append the new one.
  function automatic sm4_state_t sm4_round(sm4_state_t s, logic [31:0] rk);
    logic [31:0] b;
    b = tau(s[95:64] ^ s[63:32] ^ s[31:0] ^ rk);
    return {s[95:0], s[127:96] ^ lin_data(b)};
  endfunction

endpackage

// ----- hdl/sm4_block_cipher_unit.sv -----
// SM4 block cipher unit: key schedule and a 32-stage round pipeline.
//
// Input requests carry one 128-bit block and a direction bit (action: 0
// encrypts, 1 decrypts) on in_data, qualified by in_valid; a request is taken
// at a rising edge with in_valid high and in_stall low. Results leave on
// out_data with out_valid, and the receiver holds them with out_stall.
// Each round is one register stage, so a request taken at an edge passes
// through stages 0 to 31 in order before its result shows on the output.
// One request per cycle is accepted in steady state unless in_stall holds it.
// A stall on the output holds only the stages that are full: empty stages
// in front keep filling, so the unit goes on taking requests until all 32
// stages hold data. No request is dropped or repeated by a stall.
// The key lives in two 64-bit registers written through cfg_we, cfg_index
// and cfg_data (index 0 for the upper half, index 1 for the lower half;
// other indexes are ignored). Every key write, and reset itself, starts a
// key expansion that computes one round key per cycle until all 32 are done;
// while it runs in_stall is high. Reset clears the key to zero, empties the
// pipeline and expands the all-zero key. Keys may only change while no
// request is in flight.
module sm4_block_cipher_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sm4_pkg::sm4_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sm4_pkg::sm4_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [sm4_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sm4_pkg::KEY_W-1:0]           cfg_data
);
  import sm4_pkg::*;

  // Key registers and key schedule sequencer.
  logic [KEY_W-1:0]    key_high_r, key_low_r;
  logic [KEY_W-1:0]    key_high_nxt, key_low_nxt;
  logic                key_busy_r;
  logic [RK_IDX_W-1:0] key_cnt_r;
  logic [31:0]         kw_r [4];
  logic [31:0]         rk_r [NUM_ROUNDS];
  logic                cfg_hit;
  logic [31:0]         ks_nk;

  assign cfg_hit      = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
  assign key_high_nxt = (cfg_we && cfg_index == REG_KEY_HIGH) ? cfg_data : key_high_r;
  assign key_low_nxt  = (cfg_we && cfg_index == REG_KEY_LOW)  ? cfg_data : key_low_r;

  // One key schedule round per cycle over the sliding four-word window.
  assign ks_nk = kw_r[0] ^ lin_key(tau(kw_r[1] ^ kw_r[2] ^ kw_r[3] ^ ck_word(key_cnt_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      key_busy_r <= 1'b1;
      key_cnt_r  <= '0;
      for (int i = 0; i < 4; i++) begin
        kw_r[i] <= FK_TAB[i];
      end
    end else if (cfg_hit) begin
      key_high_r <= key_high_nxt;
      key_low_r  <= key_low_nxt;
      key_busy_r <= 1'b1;
      key_cnt_r  <= '0;
      kw_r[0]    <= key_high_nxt[63:32] ^ FK_TAB[0];
      kw_r[1]    <= key_high_nxt[31:0]  ^ FK_TAB[1];
      kw_r[2]    <= key_low_nxt[63:32]  ^ FK_TAB[2];
      kw_r[3]    <= key_low_nxt[31:0]   ^ FK_TAB[3];
    end else if (key_busy_r) begin
      kw_r[0]   <= kw_r[1];
      kw_r[1]   <= kw_r[2];
      kw_r[2]   <= kw_r[3];
      kw_r[3]   <= ks_nk;
      key_cnt_r <= key_cnt_r + RK_IDX_W'(1);
      if (key_cnt_r == RK_IDX_W'(NUM_ROUNDS - 1)) begin
        key_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n && key_busy_r && !cfg_hit) begin
      rk_r[key_cnt_r] <= ks_nk;
    end
  end

  // Round pipeline. Stage k holds the state after round k. A stage loads
  // when it is empty or when the stage after it moves on.
  sm4_state_t          st_r  [NUM_ROUNDS];
  logic [NUM_ROUNDS-1:0] dec_r;
  logic [NUM_ROUNDS-1:0] st_v_r;
  logic [NUM_ROUNDS-1:0] adv;
  logic                in_take;

  assign in_stall = key_busy_r || !adv[0];
  assign in_take  = in_valid && !in_stall;

  for (genvar k = 0; k < NUM_ROUNDS; k++) begin : g_stage
    sm4_state_t  src;
    logic        src_dec;
    logic        src_v;
    logic [31:0] rk;

    if (k == 0) begin : g_first
      assign src     = {in_data.block_high, in_data.block_low};
      assign src_dec = in_data.action;
      assign src_v   = in_take;
    end else begin : g_rest
      assign src     = st_r[k-1];
      assign src_dec = dec_r[k-1];
      assign src_v   = st_v_r[k-1];
    end

    if (k == NUM_ROUNDS - 1) begin : g_last_adv
      assign adv[k] = !st_v_r[k] || !out_stall;
    end else begin : g_mid_adv
      assign adv[k] = !st_v_r[k] || adv[k+1];
    end

    // Decryption walks the round keys from the last one down.
    assign rk = src_dec ? rk_r[NUM_ROUNDS-1-k] : rk_r[k];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        st_v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        st_r[k]  <= sm4_round(src, rk);
        dec_r[k] <= src_dec;
      end
    end
  end

  // The result is the final four words in reverse order.
  assign out_valid            = st_v_r[NUM_ROUNDS-1];
  assign out_data.result_high = {st_r[NUM_ROUNDS-1][31:0],  st_r[NUM_ROUNDS-1][63:32]};
  assign out_data.result_low  = {st_r[NUM_ROUNDS-1][95:64], st_r[NUM_ROUNDS-1][127:96]};

`ifndef ASSERT_OFF
  // No request may enter while round keys are being recomputed.
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    key_busy_r |-> in_stall)
    else $error("request accepted during key expansion");

  // A valid key write always restarts the expansion from the first round.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (key_busy_r && key_cnt_r == '0))
    else $error("key write did not restart expansion");

  // Expansion ends right after the last round key unless a new write arrives.
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    (key_busy_r && !cfg_hit && key_cnt_r == RK_IDX_W'(NUM_ROUNDS - 1)) |=> !key_busy_r)
    else $error("key expansion overran");

  // A full last stage that is stalled keeps its result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result lost or changed");
`endif

endmodule

// ----- bench/sm4_result_checker.sv -----
// Result checker for the SM4 cipher unit: predicts every block and compares results.
module sm4_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  sm4_pkg::sm4_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  sm4_pkg::sm4_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sm4_pkg::KEY_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import sm4_pkg::*;

  localparam logic [7:0] SUBST [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
    8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
    8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
    8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
    8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
    8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
    8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
    8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
    8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
    8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
    8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
    8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
    8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
    8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
    8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
    8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
    8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
    8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
    8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
    8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
  };

  // System parameters that whiten the key before expansion.
  localparam logic [31:0] KEY_WHITEN [4] = '{
    32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
  };

  logic [63:0] key_hi;
  logic [63:0] key_lo;
  logic [31:0] round_keys [32];
  sm4_out_t    predicted_blocks [$];
  int          error_total;

  function automatic logic [31:0] subst_word(logic [31:0] w);
    return {SUBST[w[31:24]], SUBST[w[23:16]], SUBST[w[15:8]], SUBST[w[7:0]]};
  endfunction

  function automatic logic [31:0] rol(logic [31:0] w, int unsigned n);
    logic [63:0] twin;
    twin = {w, w} << n;
    return twin[63:32];
  endfunction

  function automatic logic [31:0] chain_const(int i);
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      w = {w[23:0], 8'((4 * i + j) * 7)};
    end
    return w;
  endfunction

  function automatic void rebuild_round_keys();
    logic [31:0] k [4];
    logic [31:0] b;
    k[0] = key_hi[63:32] ^ KEY_WHITEN[0];
    k[1] = key_hi[31:0]  ^ KEY_WHITEN[1];
    k[2] = key_lo[63:32] ^ KEY_WHITEN[2];
    k[3] = key_lo[31:0]  ^ KEY_WHITEN[3];
    for (int i = 0; i < 32; i++) begin
      b = subst_word(k[1] ^ k[2] ^ k[3] ^ chain_const(i));
      round_keys[i] = k[0] ^ b ^ rol(b, 13) ^ rol(b, 23);
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = round_keys[i];
    end
  endfunction

  // Decryption walks the same rounds with the round keys taken backward.
  function automatic sm4_out_t sm4_transform(sm4_in_t req);
    logic [31:0] x [4];
    logic [31:0] b;
    logic [31:0] nx;
    sm4_out_t    r;
    x[0] = req.block_high[63:32];
    x[1] = req.block_high[31:0];
    x[2] = req.block_low[63:32];
    x[3] = req.block_low[31:0];
    for (int i = 0; i < 32; i++) begin
      b = subst_word(x[1] ^ x[2] ^ x[3] ^ round_keys[req.action ? 31 - i : i]);
      nx = x[0] ^ b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nx;
    end
    r.result_high = {x[3], x[2]};
    r.result_low  = {x[1], x[0]};
    return r;
  endfunction

  always @(posedge clk) begin
    sm4_out_t want;
    if (!rst_n) begin
      key_hi = '0;
      key_lo = '0;
      rebuild_round_keys();
      predicted_blocks.delete();
      error_total = 0;
    end else begin
      // Only the two key indexes exist; anything else leaves the schedule alone.
      if (cfg_we) begin
        if (cfg_index == REG_KEY_HIGH) begin
          key_hi = cfg_data;
          rebuild_round_keys();
        end else if (cfg_index == REG_KEY_LOW) begin
          key_lo = cfg_data;
          rebuild_round_keys();
        end
      end
      // Results are checked before this edge's request is queued.
      if (out_valid && !out_stall) begin
        if (predicted_blocks.size() == 0) begin
          $error("result with no request outstanding: %h %h",
                 out_data.result_high, out_data.result_low);
          error_total++;
        end else begin
          want = predicted_blocks.pop_front();
          if (out_data.result_high !== want.result_high) begin
            $error("result_high: expected %h, got %h", want.result_high,
                   out_data.result_high);
            error_total++;
          end
          if (out_data.result_low !== want.result_low) begin
            $error("result_low: expected %h, got %h", want.result_low,
                   out_data.result_low);
            error_total++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predicted_blocks.push_back(sm4_transform(in_data));
      end
    end
    mismatches  <= error_total;
    outstanding <= predicted_blocks.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the SM4 cipher unit bench: clock, reset, stimulus, flow control and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sm4_pkg::*;

  // Direction bit of a request.
  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  // Register indexes that do not exist and must be ignored by the unit.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = '1;

  // Longest stretch without any accepted transfer before the run is declared hung.
  // The longest legal quiet stretch is the receiver hold-off plus a key expansion.
  localparam int QUIET_LIMIT    = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int ITEMS_PER_MODE = 600;
  localparam int REKEY_EVERY    = 150;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  sm4_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sm4_out_t             out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_data  = '0;

  int          fail_total;
  int          open_total;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int          quiet_cycles   = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  sm4_block_cipher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sm4_result_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (fail_total),
    .outstanding (open_total)
  );

  // Offers one request, with random idle cycles in front of it, and returns at
  // the edge that accepts it. Valid stays high afterwards, so back-to-back
  // requests never lower and raise it within one time step.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic act);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {hi, lo, act};
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every request has produced its result.
  // The key may only be changed once the pipeline has drained like this.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_total != 0);
  endtask

  // One register write. The trailing cycle with the enable low lets two
  // writes follow each other without two assignments in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
    write_reg(REG_KEY_HIGH, hi);
    write_reg(REG_KEY_LOW, lo);
  endtask

  // Mostly random 64-bit halves, with the all-zero and all-one extremes mixed in.
  function automatic logic [63:0] rand_half();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Receiver flow control. A hold-off request from the stimulus freezes the
  // output for a long stretch, counted here, so that all 32 stages fill and
  // the unit has to stall its input while the sender keeps offering.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: any accepted request, result or register write restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sm4_block_cipher_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // The key after reset is all zero; the unit first expands it, which
    // shows up as a stalled input that send_block simply waits out.
    send_block('0, '0, ACT_ENCRYPT);
    send_block('1, '1, ACT_ENCRYPT);
    send_block('0, '0, ACT_DECRYPT);
    send_block('1, '1, ACT_DECRYPT);
    wait_idle();

    // Published key and plaintext, then the matching ciphertext decrypted,
    // followed by walking-bit and alternating patterns in both directions.
    set_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, ACT_ENCRYPT);
    send_block(64'h681EDF34D206965E, 64'h86B3E94F536E4246, ACT_DECRYPT);
    send_block(64'h8000000000000000, 64'h0000000000000001, ACT_ENCRYPT);
    send_block(64'h0000000000000001, 64'h8000000000000000, ACT_DECRYPT);
    send_block(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, ACT_ENCRYPT);
    send_block(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, ACT_DECRYPT);
    wait_idle();

    // Writing only the upper half must expand a key that mixes the new upper
    // half with the lower half that was already there.
    write_reg(REG_KEY_HIGH, '1);
    send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, ACT_ENCRYPT);
    send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, ACT_DECRYPT);
    wait_idle();

    // Writes to indexes past the key registers change nothing.
    write_reg(REG_SPARE, {$urandom, $urandom});
    write_reg(REG_TOP_INDEX, {$urandom, $urandom});
    send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, ACT_ENCRYPT);
    send_block('1, '0, ACT_DECRYPT);
    wait_idle();

    // All-one key, then back to the all-zero key through explicit writes.
    write_reg(REG_KEY_LOW, '1);
    send_block('0, '1, ACT_ENCRYPT);
    send_block('1, '0, ACT_DECRYPT);
    wait_idle();
    set_key('0, '0);
    send_block('0, '1, ACT_DECRYPT);
    send_block('1, '0, ACT_ENCRYPT);

    // Random part in three flow-control modes: sender mostly busy with a
    // congested receiver, the reverse, and finally full streaming. The key
    // changes at regular points, each after a full drain of the pipeline.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_gap_pct   = 14;
          recv_stall_pct = 47;
        end
        1: begin
          send_gap_pct   = 47;
          recv_stall_pct = 14;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_MODE; n++) begin
        if (n % REKEY_EVERY == 0) begin
          wait_idle();
          case ($urandom_range(3))
            0: write_reg(REG_KEY_HIGH, rand_half());
            1: write_reg(REG_KEY_LOW, rand_half());
            default: set_key(rand_half(), rand_half());
          endcase
        end
        if (mode == 0 && n == ITEMS_PER_MODE / 2) begin
          hold_req = 1'b1;
        end
        send_block(rand_half(), rand_half(), 1'($urandom_range(1)));
      end
    end

    wait_idle();
    // A short grace period catches any result that arrives unrequested.
    repeat (40) @(posedge clk);
    if (fail_total == 0 && open_total == 0) begin
      $display("sm4_block_cipher_unit test passed");
    end else begin
      $display("sm4_block_cipher_unit test failed");
    end
    $finish;
  end

endmodule
